// File: hdl/lpcd_pkg.sv
package lpcd_pkg;

   localparam int CNT_BITS    = 15;
   localparam int WORD_BITS   = 16;
   localparam int STEP_BITS   = 16;
   localparam int TABLE_DEPTH = 2 ** CNT_BITS;
   localparam int TABLE_STEPS = 32768;
   localparam int TAP_HIGH    = 14;
   localparam int TAP_LOW     = 6;

   typedef logic [WORD_BITS-1:0] raw_word_type;
   typedef logic [CNT_BITS-1:0]  count_type;
   typedef logic [STEP_BITS-1:0] step_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_WALK  = 3'b010,
      ST_RUN   = 3'b100
   } fill_state_type;

   function automatic count_type lfsr_next(input count_type s);
      lfsr_next = {s[CNT_BITS-2:0], ~(s[TAP_HIGH] ^ s[TAP_LOW])};
   endfunction

endpackage

// File: hdl/lpcd_if.sv
interface lpcd_req_if import lpcd_pkg::*; ();
   logic         valid;
   logic         ready;
   raw_word_type raw_word;

   modport source (output valid, output raw_word, input ready);
   modport sink   (input valid, input raw_word, output ready);
endinterface

interface lpcd_rsp_if import lpcd_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type count;

   modport source (output valid, output count, input ready);
   modport sink   (input valid, input count, output ready);
endinterface

// File: hdl/lpcd_ram.sv
module lpcd_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/lfsr_pixel_counter_decode.sv
// A result passes the input register, the table read register and the output register
// in turn after its beat is accepted.
// Throughput: one beat per cycle; each stage holds under a stall and bubbles collapse.
// Reset: synchronous, active high. Afterwards the table is cleared entry by entry,
// then filled by the LFSR walk; no input is taken until done.
module lfsr_pixel_counter_decode import lpcd_pkg::*; (
   input logic        clock,
   input logic        reset,
   lpcd_req_if.sink   req_chan,
   lpcd_rsp_if.source rsp_chan
);

   fill_state_type state_ff, state_in;
   count_type      clr_ff, clr_in;
   count_type      walk_ff, walk_in;
   step_type       step_ff, step_in;

   logic           v1_ff, v1_in;
   logic           v2_ff, v2_in;
   logic           v3_ff, v3_in;
   count_type      addr_ff, addr_in;
   count_type      count_ff, count_in;
   count_type      rd_data;

   logic           en1, en2, en3;
   logic           wr_en;
   count_type      wr_addr;
   count_type      wr_data;
   count_type      walk_next;

   // fill sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      walk_in   = walk_ff;
      step_in   = step_ff;
      wr_en     = 1'b0;
      wr_addr   = clr_ff;
      wr_data   = '0;
      walk_next = lfsr_next(walk_ff);
      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == count_type'(TABLE_DEPTH - 1)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            wr_en = 1'b1;
            if (step_ff >= step_type'(TABLE_STEPS)) begin
               wr_addr  = '0;
               state_in = ST_RUN;
            end else begin
               wr_addr = walk_next;
               wr_data = step_ff[CNT_BITS-1:0];
               walk_in = walk_next;
               step_in = step_ff + 1'b1;
            end
         end
         ST_RUN: begin
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // lookup pipeline
   assign en3 = !v3_ff || rsp_chan.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1 && (state_ff == ST_RUN);

   always_comb begin
      v1_in    = v1_ff;
      addr_in  = addr_ff;
      v2_in    = v2_ff;
      v3_in    = v3_ff;
      count_in = count_ff;
      if (en1) begin
         v1_in   = req_chan.valid && req_chan.ready;
         addr_in = req_chan.raw_word[CNT_BITS-1:0];
      end
      if (en2) begin
         v2_in = v1_ff;
      end
      if (en3) begin
         v3_in    = v2_ff;
         count_in = rd_data;
      end
   end

   lpcd_ram #(
      .WIDTH (CNT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (en2),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         walk_ff  <= '0;
         step_ff  <= step_type'(1);
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         walk_ff  <= walk_in;
         step_ff  <= step_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      count_ff <= count_in;
   end

   assign rsp_chan.valid = v3_ff;
   assign rsp_chan.count = count_ff;

endmodule

// File: tb/lfsr_pixel_counter_decode_test.sv
`timescale 1ns / 100ps

module lfsr_pixel_counter_decode_test;
   import lpcd_pkg::*;

   localparam int RANDOM_WORDS = 1750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 8;
   localparam int SHOWN_ERRORS = 10;

   class count_checker;
      count_type step_of_state[TABLE_DEPTH];
      count_type state_at_step[TABLE_STEPS];
      count_type pending_counts[$];
      int        mismatches;
      int        counts_seen;

      function new();
         count_type state;
         logic      feedback;
         foreach (step_of_state[i]) step_of_state[i] = '0;
         state = '0;
         state_at_step[0] = '0;
         for (int step = 1; step < TABLE_STEPS; step++) begin
            feedback = state[TAP_HIGH] ~^ state[TAP_LOW];
            state = (state << 1) | count_type'(feedback);
            state_at_step[step] = state;
            step_of_state[state] = count_type'(step);
         end
         // state zero always reads back as zero, also on a full-period wrap
         step_of_state[0] = '0;
         mismatches = 0;
         counts_seen = 0;
      endfunction

      function void note_word(raw_word_type word);
         pending_counts.push_back(step_of_state[word[CNT_BITS-1:0]]);
      endfunction

      function void check_count(count_type got);
         count_type want;
         counts_seen++;
         if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("unexpected count beat: got %0d", got);
            return;
         end
         want = pending_counts.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("count mismatch at beat %0d: expected %0d, actual %0d",
                        counts_seen, want, got);
         end
      endfunction

      function int outstanding();
         return pending_counts.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;

   lpcd_req_if req_chan();
   lpcd_rsp_if rsp_chan();

   count_checker book = new();

   lfsr_pixel_counter_decode u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
         book.note_word(req_chan.raw_word);
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         book.check_count(rsp_chan.count);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: ~6% stalls, none while beats 600..999 come back
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (book.counts_seen >= 600 && book.counts_seen < 1000)
            rsp_chan.ready <= 1'b1;
         else
            rsp_chan.ready <= ($urandom_range(0, 99) >= 6);
      end
   end

   task automatic send_word(input raw_word_type word);
      req_chan.valid    <= 1'b1;
      req_chan.raw_word <= word;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic hold_off(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (book.outstanding() != 0);
   endtask

   function automatic raw_word_type pick_word();
      raw_word_type word;
      if ($urandom_range(0, 99) < 60) begin
         word = raw_word_type'(book.state_at_step[$urandom_range(0, TABLE_STEPS - 1)]);
         word[WORD_BITS-1] = 1'($urandom_range(0, 1));
      end else begin
         word = raw_word_type'($urandom_range(0, 65535));
      end
      return word;
   endfunction

   initial begin
      raw_word_type directed[$];

      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.raw_word <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      directed = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFE, 16'h3FFF,
                   16'h4000, 16'h0040, 16'hC040, 16'h5555, 16'hAAAA};
      directed.push_back(raw_word_type'(book.state_at_step[1]));
      directed.push_back(raw_word_type'(book.state_at_step[2]) | 16'h8000);
      directed.push_back(raw_word_type'(book.state_at_step[TABLE_STEPS / 2]));
      directed.push_back(raw_word_type'(book.state_at_step[TABLE_STEPS - 2]));
      directed.push_back(raw_word_type'(book.state_at_step[TABLE_STEPS - 1]) | 16'h8000);
      directed.push_back(raw_word_type'(book.state_at_step[TABLE_STEPS - 1]));
      foreach (directed[i])
         send_word(directed[i]);
      wait_drained();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 1000)
            wait_drained();
         else if ((n < 500 || n >= 900) && $urandom_range(0, 99) < 6)
            hold_off($urandom_range(1, 2));
         send_word(pick_word());
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.outstanding() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
